FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/pas_pkg.sv
package pas_pkg;

  localparam int VOICE_COUNT     = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TIME_BITS       = 24;

  localparam int VOICE_IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int ELAPSED_W   = TIME_BITS + 2;
  localparam int NUM_W       = TIME_BITS + 16;
  localparam int SUM_W       = 50 + VOICE_IDX_W + 1;
  localparam int QW          = SINE_TABLE_BITS - 2;
  localparam int QUARTER     = 1 << QW;

  localparam logic [14:0] MIX_GAIN_RESET = 15'd4915;
  localparam logic [31:0] LFSR_SEED      = 32'h0000ACE1;
  localparam logic [31:0] LFSR_TAPS      = 32'hD0000001;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  localparam logic [2:0] WV_SINE     = 3'd0;
  localparam logic [2:0] WV_SQUARE   = 3'd1;
  localparam logic [2:0] WV_TRIANGLE = 3'd2;
  localparam logic [2:0] WV_SAW      = 3'd3;
  localparam logic [2:0] WV_NOISE    = 3'd4;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_NOTE_ON = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_EVAL, ST_MUL, ST_DIV, ST_AMP, ST_WPROD, ST_GPROD, ST_ACC, ST_DONE
  } state_t;

  typedef enum logic [1:0] {SEG_ATT, SEG_DEC, SEG_SUS, SEG_REL} seg_t;

  typedef struct packed {
    logic [31:0]          phase;
    logic [31:0]          step;
    logic [ELAPSED_W-1:0] elapsed;
    logic [TIME_BITS-1:0] dur;
    logic [TIME_BITS-1:0] att;
    logic [TIME_BITS-1:0] dec;
    logic [TIME_BITS-1:0] rel;
    logic [15:0]          sus;
    logic [2:0]           wave;
  } voice_t;

  typedef logic [15:0] sine_rom_t [QUARTER];

  // Quarter-wave sine entry from a fixed-point Taylor series.
  function automatic logic [15:0] quarter_sine(int unsigned k);
    logic [63:0] x, x2, term, r;
    longint sum;
    x    = (64'(k) * HALF_PI_Q30) >> QW;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    if (sum < 0) sum = 0;
    r = (64'(sum) + 64'd16384) >> 15;
    if (r > 64'd32768) r = 64'd32768;
    return 16'(r);
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t tab;
    for (int k = 0; k < QUARTER; k++) tab[k] = quarter_sine(k);
    return tab;
  endfunction

  localparam sine_rom_t   SINE_ROM  = build_sine();
  localparam logic [15:0] SINE_PEAK = quarter_sine(QUARTER);

endpackage

FILE: hw/rtl/pas_voice_ram.sv
module pas_voice_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/pas_divider.sv
module pas_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pas_pkg::NUM_W-1:0]     num,
  input  logic [pas_pkg::TIME_BITS-1:0] den,
  output logic                          done,
  output logic [pas_pkg::NUM_W-1:0]     quot
);

  localparam int CNT_W = $clog2(pas_pkg::NUM_W + 1);

  logic [pas_pkg::TIME_BITS:0]   rem;
  logic [pas_pkg::TIME_BITS-1:0] den_r;
  logic [CNT_W-1:0]              cnt;
  logic                          running;
  logic [pas_pkg::TIME_BITS+1:0] rem_sh;
  logic [pas_pkg::TIME_BITS+1:0] rem_sub;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    rem_sh  = {rem, quot[pas_pkg::NUM_W-1]};
    rem_sub = rem_sh - (pas_pkg::TIME_BITS + 2)'(den_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(pas_pkg::NUM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      quot  <= num;
    end else if (running) begin
      if (!rem_sub[pas_pkg::TIME_BITS+1]) begin
        rem  <= rem_sub[pas_pkg::TIME_BITS:0];
        quot <= {quot[pas_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[pas_pkg::TIME_BITS:0];
        quot <= {quot[pas_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hw/rtl/polyphonic_adsr_synth.sv
// Note-on: its acknowledgment strobes on done in the cycle after the transfer; one per cycle while idle.
// Tick: done strobes after the transfer once all voices are walked: an idle voice takes scan,
// one that ends scan and eval, a sustaining one adds amp, wprod, gprod and acc, and one in
// attack, decay or release also waits on the serial divider. Busy falls with the strobe.
// Results are shown for one cycle on done and cannot be stalled by the receiver.
// Reset (rst, synchronous): voices idle, mix_gain 4915, LFSR 0xACE1; voice memory not cleared.
module polyphonic_adsr_synth (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [31:0]        phase_step,
  input  logic [23:0]        duration,
  input  logic [23:0]        attack,
  input  logic [23:0]        decay,
  input  logic [15:0]        sustain,
  input  logic [23:0]        release_req,
  input  logic [2:0]         wave,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data,
  output logic               done,
  output logic               is_sample,
  output logic signed [15:0] sample,
  output logic [3:0]         voice_slot,
  output logic               voice_stolen
);

  localparam int VW = pas_pkg::VOICE_IDX_W;
  localparam int EW = pas_pkg::ELAPSED_W;
  localparam int TB = pas_pkg::TIME_BITS;
  localparam int SW = pas_pkg::SUM_W;
  localparam int QW_T = pas_pkg::QW;

  pas_pkg::state_t state, state_next;

  // Control state.
  logic [pas_pkg::VOICE_COUNT-1:0] active;
  logic [VW-1:0]                   vidx;
  logic [14:0]                     mix_gain;
  logic [31:0]                     lfsr;

  // Per-voice working registers.
  pas_pkg::seg_t       seg;
  logic [TB-1:0]       opa;
  logic [15:0]         opb;
  logic [TB-1:0]       den;
  logic [15:0]         sus_r;
  logic signed [16:0]  wave_val;
  logic [15:0]         amp;
  logic signed [33:0]  prod1;
  logic signed [49:0]  prod2;
  logic signed [SW-1:0] sum;

  // Memory port.
  logic                 mem_we, mem_re;
  logic [VW-1:0]        mem_waddr;
  pas_pkg::voice_t      mem_wdata, rd;

  // Divider port.
  logic                      div_start, div_done;
  logic [pas_pkg::NUM_W-1:0] div_quot;

  // Note-on slot selection.
  logic          free_found;
  logic [VW-1:0] free_slot;
  logic [VW-1:0] claim_slot;
  logic          accept;

  // Envelope and wave evaluation from the voice just read.
  logic [EW-1:0]       t;
  logic [EW-1:0]       att_end, rel_end;
  logic                ev_live;
  pas_pkg::seg_t       ev_seg;
  logic [TB-1:0]       ev_opa;
  logic [15:0]         ev_opb;
  logic [TB-1:0]       ev_den;
  logic [31:0]         lfsr_adv;
  logic [VW-1:0]       vidx_step;
  logic                last_voice;
  logic signed [16:0]  ev_wave;
  logic [QW_T-1:0]     sine_k;
  logic [QW_T-1:0]     sine_kr;
  logic [15:0]         sine_mag;
  logic signed [16:0]  saw_u;
  logic [16:0]         saw_abs;
  logic signed [17:0]  tri_w;
  logic [15:0]         sus_clamped;
  logic signed [SW-1:0] biased, shifted;

  assign busy      = (state != pas_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign vidx_step = vidx + 1'b1;
  assign last_voice = (vidx == VW'(pas_pkg::VOICE_COUNT - 1));

  // Lowest idle voice; slot 0 is stolen when all are busy.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = pas_pkg::VOICE_COUNT - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_slot  = VW'(i);
      end
    end
    claim_slot = free_found ? free_slot : '0;
  end

  assign sus_clamped = (sustain > 16'd32768) ? 16'd32768 : sustain;

  // Envelope segment selection. Elapsed saturates at its all-ones value.
  always_comb begin
    t       = (rd.elapsed != {EW{1'b1}}) ? rd.elapsed + 1'b1 : rd.elapsed;
    att_end = EW'(rd.att) + EW'(rd.dec);
    rel_end = EW'(rd.dur) + EW'(rd.rel);
    ev_live = 1'b1;
    ev_seg  = pas_pkg::SEG_SUS;
    ev_opa  = '0;
    ev_opb  = '0;
    ev_den  = '0;
    if (t < EW'(rd.att)) begin
      ev_seg = pas_pkg::SEG_ATT;
      ev_opa = TB'(t);
      ev_opb = 16'h8000;
      ev_den = rd.att;
    end else if (t < att_end) begin
      ev_seg = pas_pkg::SEG_DEC;
      ev_opa = TB'(t - EW'(rd.att));
      ev_opb = 16'(17'd32768 - 17'(rd.sus));
      ev_den = rd.dec;
    end else if (t < EW'(rd.dur)) begin
      ev_seg = pas_pkg::SEG_SUS;
    end else if (t < rel_end) begin
      ev_seg = pas_pkg::SEG_REL;
      ev_opa = TB'(EW'(rd.rel) - (t - EW'(rd.dur)));
      ev_opb = rd.sus;
      ev_den = rd.rel;
    end else begin
      ev_live = 1'b0;
    end
  end

  // Wave value from the phase before it advances.
  always_comb begin
    lfsr_adv = (lfsr >> 1) ^ (lfsr[0] ? pas_pkg::LFSR_TAPS : 32'd0);
    sine_k   = rd.phase[31-2 -: QW_T];
    sine_kr  = ~sine_k + 1'b1;
    case (rd.phase[31:30]) inside
      2'd0, 2'd2: sine_mag = pas_pkg::SINE_ROM[sine_k];
      default:    sine_mag = (sine_k == '0) ? pas_pkg::SINE_PEAK
                                            : pas_pkg::SINE_ROM[sine_kr];
    endcase
    saw_u   = 17'(signed'({~rd.phase[31], rd.phase[30:16]}));
    saw_abs = saw_u[16] ? 17'(-saw_u) : 17'(saw_u);
    tri_w   = signed'({saw_abs, 1'b0}) - 18'sd32768;
    case (rd.wave)
      pas_pkg::WV_SINE:
        ev_wave = rd.phase[31] ? -signed'({1'b0, sine_mag}) : signed'({1'b0, sine_mag});
      pas_pkg::WV_SQUARE:   ev_wave = rd.phase[31] ? -17'sd32768 : 17'sd32768;
      pas_pkg::WV_TRIANGLE: ev_wave = 17'(tri_w);
      pas_pkg::WV_SAW:      ev_wave = saw_u;
      pas_pkg::WV_NOISE:
        ev_wave = 17'(signed'({~lfsr_adv[31], lfsr_adv[30:16]}));
      default:              ev_wave = '0;
    endcase
  end

  // Mix sum divided by 2^30, rounded toward zero, then saturated.
  always_comb begin
    biased  = sum[SW-1] ? sum + SW'(32'h3FFFFFFF) : sum;
    shifted = biased >>> 30;
  end

  // Memory write data: a fresh voice on note-on, the advanced voice on a tick.
  always_comb begin
    mem_wdata = rd;
    mem_waddr = vidx;
    if (state == pas_pkg::ST_IDLE) begin
      mem_waddr         = claim_slot;
      mem_wdata.phase   = '0;
      mem_wdata.step    = phase_step;
      mem_wdata.elapsed = '0;
      mem_wdata.dur     = TB'(duration);
      mem_wdata.att     = TB'(attack);
      mem_wdata.dec     = TB'(decay);
      mem_wdata.rel     = TB'(release_req);
      mem_wdata.sus     = sus_clamped;
      mem_wdata.wave    = wave;
    end else begin
      mem_wdata.phase   = rd.phase + rd.step;
      mem_wdata.elapsed = t;
    end
  end

  // Sequencer: each tick walks the voices in index order, one read-modify-write per live voice.
  // Every active voice is read once and, if still live, written back before the next read, so
  // accesses never overlap on one entry.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      pas_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd == pas_pkg::CMD_NOTE_ON) mem_we = 1'b1;
          else state_next = pas_pkg::ST_SCAN;
        end
      end
      pas_pkg::ST_SCAN: begin
        if (active[vidx]) begin
          mem_re     = 1'b1;
          state_next = pas_pkg::ST_EVAL;
        end else if (last_voice) begin
          state_next = pas_pkg::ST_DONE;
        end
      end
      pas_pkg::ST_EVAL: begin
        if (!ev_live) begin
          state_next = last_voice ? pas_pkg::ST_DONE : pas_pkg::ST_SCAN;
        end else begin
          mem_we     = 1'b1;
          state_next = (ev_seg == pas_pkg::SEG_SUS) ? pas_pkg::ST_AMP : pas_pkg::ST_MUL;
        end
      end
      pas_pkg::ST_MUL: begin
        div_start  = 1'b1;
        state_next = pas_pkg::ST_DIV;
      end
      pas_pkg::ST_DIV:   if (div_done) state_next = pas_pkg::ST_AMP;
      pas_pkg::ST_AMP:   state_next = pas_pkg::ST_WPROD;
      pas_pkg::ST_WPROD: state_next = pas_pkg::ST_GPROD;
      pas_pkg::ST_GPROD: state_next = pas_pkg::ST_ACC;
      pas_pkg::ST_ACC:   state_next = last_voice ? pas_pkg::ST_DONE : pas_pkg::ST_SCAN;
      pas_pkg::ST_DONE:  state_next = pas_pkg::ST_IDLE;
      default:           state_next = pas_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pas_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Control registers: voice valid bits, voice index, gain, noise generator, strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= '0;
      vidx     <= '0;
      mix_gain <= pas_pkg::MIX_GAIN_RESET;
      lfsr     <= pas_pkg::LFSR_SEED;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) mix_gain <= cfg_data;
      unique case (state)
        pas_pkg::ST_IDLE: begin
          vidx <= '0;
          if (accept && cmd == pas_pkg::CMD_NOTE_ON) begin
            active[claim_slot] <= 1'b1;
            done               <= 1'b1;
          end
        end
        pas_pkg::ST_SCAN: if (!active[vidx] && !last_voice) vidx <= vidx_step;
        pas_pkg::ST_EVAL: begin
          if (!ev_live) begin
            active[vidx] <= 1'b0;
            if (!last_voice) vidx <= vidx_step;
          end else if (rd.wave == pas_pkg::WV_NOISE) begin
            lfsr <= lfsr_adv;
          end
        end
        pas_pkg::ST_ACC:  if (!last_voice) vidx <= vidx_step;
        pas_pkg::ST_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      pas_pkg::ST_IDLE: begin
        sum <= '0;
        if (accept && cmd == pas_pkg::CMD_NOTE_ON) begin
          is_sample    <= 1'b0;
          sample       <= '0;
          voice_slot   <= 4'(claim_slot);
          voice_stolen <= !free_found;
        end
      end
      pas_pkg::ST_EVAL: begin
        seg      <= ev_seg;
        opa      <= ev_opa;
        opb      <= ev_opb;
        den      <= ev_den;
        sus_r    <= rd.sus;
        wave_val <= ev_wave;
      end
      pas_pkg::ST_AMP: begin
        case (seg)
          pas_pkg::SEG_DEC: amp <= 16'(17'd32768 - 17'(div_quot[15:0]));
          pas_pkg::SEG_SUS: amp <= sus_r;
          default:          amp <= div_quot[15:0];
        endcase
      end
      pas_pkg::ST_WPROD: prod1 <= wave_val * signed'({1'b0, amp});
      pas_pkg::ST_GPROD: prod2 <= prod1 * signed'({1'b0, mix_gain});
      pas_pkg::ST_ACC:   sum   <= sum + SW'(prod2);
      pas_pkg::ST_DONE: begin
        is_sample    <= 1'b1;
        voice_slot   <= '0;
        voice_stolen <= 1'b0;
        if (shifted > SW'(32767))       sample <= 16'sh7FFF;
        else if (shifted < -SW'(32768)) sample <= 16'sh8000;
        else                            sample <= 16'(shifted);
      end
      default: ;
    endcase
  end

  pas_voice_ram #(
    .WIDTH($bits(pas_pkg::voice_t)),
    .DEPTH(pas_pkg::VOICE_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(vidx),
    .rdata(rd)
  );

  // Envelope numerator is formed here and registered inside the divider.
  pas_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (pas_pkg::NUM_W'(opa) * pas_pkg::NUM_W'(opb)),
    .den  (den),
    .done (div_done),
    .quot (div_quot)
  );

endmodule

FILE: hw/rtl/pas_checker.sv
`include "assert_macros.svh"

module pas_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        cmd,
  input logic        done,
  input logic        is_sample,
  input logic [15:0] sample,
  input logic [3:0]  voice_slot,
  input logic        voice_stolen
);

  `ASSERT_NEXT(a_note_ack, start && !busy && cmd, done && !is_sample)
  `ASSERT_NEXT(a_tick_busy, start && !busy && !cmd, busy && !done)
  `ASSERT_IMPL(a_ack_silent, done && !is_sample, sample == 16'd0)
  `ASSERT_IMPL(a_tick_fields, done && is_sample, voice_slot == 4'd0 && !voice_stolen)

endmodule

bind polyphonic_adsr_synth pas_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .cmd         (cmd),
  .done        (done),
  .is_sample   (is_sample),
  .sample      (sample),
  .voice_slot  (voice_slot),
  .voice_stolen(voice_stolen)
);
